// ===== rtl/core/exc_nest_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exception nesting tracker package
// Event and record types, field codes and sequencer states.
// ----------------------------------------------------------------------------
package exc_nest_pkg;

	// event modes
	localparam logic [2:0] MODE_ENTERED  = 3'd0;
	localparam logic [2:0] MODE_EXITED   = 3'd1;
	localparam logic [2:0] MODE_RETURNED = 3'd2;
	localparam logic [2:0] MODE_UNKNOWN  = 3'd3;
	localparam logic [2:0] MODE_START    = 3'd4;
	localparam logic [2:0] MODE_DISCONT  = 3'd5;

	// record actions
	localparam logic [1:0] ACT_ENTER  = 2'd0;
	localparam logic [1:0] ACT_EXIT   = 2'd1;
	localparam logic [1:0] ACT_RETURN = 2'd2;

	// record origins
	localparam logic ORG_TRACE = 1'b0;
	localparam logic ORG_SYNTH = 1'b1;

	localparam int NUM_W = 9;

	typedef struct packed {
		logic [2:0]       mode;
		logic [NUM_W-1:0] exc_number;
	} evt_t;

	typedef struct packed {
		logic [NUM_W-1:0] rec_number;
		logic [1:0]       rec_action;
		logic             rec_origin;
		logic             first_seen;
		logic             stack_overflow;
		logic             last;
	} rec_t;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             running;
	} stk_entry_t;

	// pending record before the seen-map lookup
	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [1:0]       action;
		logic             origin;
	} plan_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_PUSH,
		ST_SEEN_RD,
		ST_SEEN_WR,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/core/exc_nest_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exception nesting tracker RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module exc_nest_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/exception_nesting_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Exception nesting tracker
// Follows exception trace events, keeps a nesting stack and the active
// context, and emits lane records with first-sighting and overflow flags.
// ----------------------------------------------------------------------------
// Usage:
//   evt_valid/evt_stall/evt carry one trace event per transfer. The block
//   raises evt_stall whenever it is busy, so it works on one event at a time.
//   rec_valid/rec_stall/rec carry zero to two lane records per event; the
//   final record of an event has rec.last set. An event with no record
//   produces nothing on the record channel.
//   Sequence: an accepted event passes through the stack check, which repeats
//   for each stack entry popped by a return, then the push state for an
//   enter. Each record then passes through seen-map read, seen-map update
//   and output, all through the seen-map RAM with its registered read.
//   The nesting stack lives in a RAM whose top is read in idle, so the check
//   sees it right after the transfer.
//   Reset: after arst_n releases, the block sweeps the seen map clear, one
//   entry per cycle, over all NUM_EXCEPTIONS entries with evt_stall high.
//   A stalled record holds in the output register; the block accepts no new
//   event until the last record of the current one has transferred.
// ----------------------------------------------------------------------------
module exception_nesting_tracker #(
	parameter int STACK_DEPTH    = 32,
	parameter int NUM_EXCEPTIONS = 512
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               evt_valid,
	output logic                    evt_stall,
	input  wire exc_nest_pkg::evt_t evt,
	output logic                    rec_valid,
	input  wire logic               rec_stall,
	output exc_nest_pkg::rec_t      rec
);

	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int SAW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SEEN_AW = $clog2(NUM_EXCEPTIONS);
	localparam int ENT_W   = exc_nest_pkg::NUM_W + 1;
	localparam int NUM_W   = exc_nest_pkg::NUM_W;

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	exc_nest_pkg::state_t state_q, state_d;

	logic [SEEN_AW-1:0] clr_q;
	logic [CNT_W-1:0]   count_q;
	logic               active_valid_q;
	logic [NUM_W-1:0]   active_num_q;
	logic [1:0]         nrem_q;

	logic [2:0]          mode_q;
	logic [NUM_W-1:0]    num_q;
	logic                ovf_q;
	exc_nest_pkg::plan_t rec0_q, rec1_q;
	exc_nest_pkg::rec_t  out_q;

	// ------------------------------------------------------------------
	// Stack RAM and seen-map RAM
	// ------------------------------------------------------------------
	logic                     stk_we;
	logic [SAW-1:0]           stk_waddr, stk_raddr;
	logic [ENT_W-1:0]         stk_wdata, stk_rdata;
	exc_nest_pkg::stk_entry_t top_e;

	logic               seen_we, seen_wdata, seen_rdata;
	logic [SEEN_AW-1:0] seen_waddr, seen_raddr;

	exc_nest_ram #(.WIDTH(ENT_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	exc_nest_ram #(.WIDTH(1), .DEPTH(NUM_EXCEPTIONS)) u_seen_ram (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_waddr),
		.wdata (seen_wdata),
		.raddr (seen_raddr),
		.rdata (seen_rdata)
	);

	assign top_e = exc_nest_pkg::stk_entry_t'(stk_rdata);

	// ------------------------------------------------------------------
	// Stack check: decide the stack update and the record plan
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]    cnt_m1, cnt_m2, cnt_d;
	logic                has_top, top_run, full;
	logic [NUM_W-1:0]    top_num;
	logic                chk_done, chk_pop, chk_push, chk_we, chk_ovf;
	logic [SAW-1:0]      chk_waddr;
	exc_nest_pkg::stk_entry_t chk_wdata;
	logic                do_set, do_close;
	logic [NUM_W-1:0]    set_num;
	logic [1:0]          set_act;
	logic                set_org, close_org;
	exc_nest_pkg::plan_t plan0, plan1;
	logic [1:0]          plan_n;
	logic                act_valid_d;
	logic [NUM_W-1:0]    act_num_d;

	assign cnt_m1  = count_q - CNT_W'(1);
	assign cnt_m2  = count_q - CNT_W'(2);
	assign has_top = (count_q != '0);
	assign top_num = has_top ? top_e.number : '0;
	assign top_run = has_top & top_e.running;
	assign full    = (count_q == CNT_W'(STACK_DEPTH));

	always_comb begin
		chk_done  = 1'b1;
		chk_pop   = 1'b0;
		chk_push  = 1'b0;
		chk_we    = 1'b0;
		chk_ovf   = 1'b0;
		chk_waddr = cnt_m1[SAW-1:0];
		chk_wdata = '{number: num_q, running: 1'b1};
		cnt_d     = count_q;
		do_set    = 1'b0;
		do_close  = 1'b0;
		set_num   = num_q;
		set_act   = exc_nest_pkg::ACT_ENTER;
		set_org   = exc_nest_pkg::ORG_TRACE;
		close_org = exc_nest_pkg::ORG_TRACE;
		case (mode_q)
			exc_nest_pkg::MODE_ENTERED: begin
				do_set = 1'b1;
				if (full) begin
					// drop the push, the old top stays active
					chk_ovf = 1'b1;
					set_num = top_num;
				end else begin
					chk_push = 1'b1;
					if (top_run) begin
						chk_we    = 1'b1;
						chk_wdata = '{number: top_num, running: 1'b0};
					end
				end
			end
			exc_nest_pkg::MODE_EXITED: begin
				if (has_top && top_e.number == num_q && top_e.running) begin
					cnt_d    = cnt_m1;
					do_close = 1'b1;
				end
			end
			exc_nest_pkg::MODE_RETURNED: begin
				if (has_top && top_e.number != num_q) begin
					// pop one entry and read the next top
					chk_done = 1'b0;
					chk_pop  = 1'b1;
					cnt_d    = cnt_m1;
				end else begin
					do_set  = 1'b1;
					set_act = exc_nest_pkg::ACT_RETURN;
					if (has_top) begin
						chk_we = 1'b1;
					end else if (num_q != '0) begin
						chk_we    = 1'b1;
						chk_waddr = '0;
						cnt_d     = CNT_W'(1);
					end
				end
			end
			exc_nest_pkg::MODE_START: begin
				do_set  = 1'b1;
				set_num = '0;
				set_org = exc_nest_pkg::ORG_SYNTH;
			end
			exc_nest_pkg::MODE_DISCONT: begin
				cnt_d     = '0;
				do_close  = 1'b1;
				close_org = exc_nest_pkg::ORG_SYNTH;
			end
			default: begin
			end
		endcase
	end

	// record plan from the active-context update
	always_comb begin
		plan0       = '{number: set_num, action: set_act, origin: set_org};
		plan1       = '{number: set_num, action: set_act, origin: set_org};
		plan_n      = 2'd0;
		act_valid_d = active_valid_q;
		act_num_d   = active_num_q;
		if (do_set) begin
			if (active_valid_q && active_num_q == set_num) begin
				if (set_act == exc_nest_pkg::ACT_RETURN) begin
					plan_n = 2'd1;
				end
			end else begin
				if (active_valid_q) begin
					plan0  = '{number: active_num_q, action: exc_nest_pkg::ACT_EXIT,
						origin: exc_nest_pkg::ORG_SYNTH};
					plan_n = 2'd2;
				end else begin
					plan_n = 2'd1;
				end
				act_valid_d = 1'b1;
				act_num_d   = set_num;
			end
		end else if (do_close && active_valid_q) begin
			plan0       = '{number: active_num_q, action: exc_nest_pkg::ACT_EXIT,
				origin: close_org};
			plan_n      = 2'd1;
			act_valid_d = 1'b0;
			act_num_d   = '0;
		end
	end

	// ------------------------------------------------------------------
	// Seen-map lookup for the pending record
	// ------------------------------------------------------------------
	logic in_range, first;

	assign in_range = ({1'b0, rec0_q.number} < (NUM_W + 1)'(NUM_EXCEPTIONS));
	assign first    = in_range & ~seen_rdata;

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			exc_nest_pkg::ST_CLEAR: begin
				if (clr_q == SEEN_AW'(NUM_EXCEPTIONS - 1)) begin
					state_d = exc_nest_pkg::ST_IDLE;
				end
			end
			exc_nest_pkg::ST_IDLE: begin
				if (evt_valid) begin
					state_d = exc_nest_pkg::ST_CHECK;
				end
			end
			exc_nest_pkg::ST_CHECK: begin
				if (!chk_done) begin
					state_d = exc_nest_pkg::ST_CHECK;
				end else if (chk_push) begin
					state_d = exc_nest_pkg::ST_PUSH;
				end else if (plan_n != 2'd0) begin
					state_d = exc_nest_pkg::ST_SEEN_RD;
				end else begin
					state_d = exc_nest_pkg::ST_IDLE;
				end
			end
			exc_nest_pkg::ST_PUSH: begin
				state_d = (nrem_q != 2'd0) ? exc_nest_pkg::ST_SEEN_RD : exc_nest_pkg::ST_IDLE;
			end
			exc_nest_pkg::ST_SEEN_RD: state_d = exc_nest_pkg::ST_SEEN_WR;
			exc_nest_pkg::ST_SEEN_WR: state_d = exc_nest_pkg::ST_OUT;
			exc_nest_pkg::ST_OUT: begin
				if (!rec_stall) begin
					state_d = (nrem_q == 2'd1) ? exc_nest_pkg::ST_IDLE
						: exc_nest_pkg::ST_SEEN_RD;
				end
			end
			default: state_d = exc_nest_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Outputs and RAM controls
	// ------------------------------------------------------------------
	always_comb begin
		evt_stall  = (state_q != exc_nest_pkg::ST_IDLE);
		rec_valid  = (state_q == exc_nest_pkg::ST_OUT);
		rec        = out_q;

		// read the top in idle; during a pop read the entry below it
		stk_raddr  = (state_q == exc_nest_pkg::ST_CHECK && chk_pop) ? cnt_m2[SAW-1:0]
			: cnt_m1[SAW-1:0];
		stk_we     = 1'b0;
		stk_waddr  = chk_waddr;
		stk_wdata  = chk_wdata;

		seen_raddr = rec0_q.number[SEEN_AW-1:0];
		seen_we    = 1'b0;
		seen_waddr = rec0_q.number[SEEN_AW-1:0];
		seen_wdata = 1'b1;

		case (state_q)
			exc_nest_pkg::ST_CLEAR: begin
				seen_we    = 1'b1;
				seen_waddr = clr_q;
				seen_wdata = 1'b0;
			end
			exc_nest_pkg::ST_CHECK: begin
				stk_we = chk_we;
			end
			exc_nest_pkg::ST_PUSH: begin
				stk_we    = 1'b1;
				stk_waddr = count_q[SAW-1:0];
				stk_wdata = exc_nest_pkg::stk_entry_t'{number: num_q, running: 1'b1};
			end
			exc_nest_pkg::ST_SEEN_WR: begin
				seen_we = first;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= exc_nest_pkg::ST_CLEAR;
			clr_q          <= '0;
			count_q        <= '0;
			active_valid_q <= 1'b0;
			active_num_q   <= '0;
			nrem_q         <= 2'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				exc_nest_pkg::ST_CLEAR: begin
					clr_q <= clr_q + SEEN_AW'(1);
				end
				exc_nest_pkg::ST_CHECK: begin
					count_q <= cnt_d;
					if (chk_done) begin
						active_valid_q <= act_valid_d;
						active_num_q   <= act_num_d;
						nrem_q         <= plan_n;
					end
				end
				exc_nest_pkg::ST_PUSH: begin
					count_q <= count_q + CNT_W'(1);
				end
				exc_nest_pkg::ST_OUT: begin
					if (!rec_stall) begin
						nrem_q <= nrem_q - 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			exc_nest_pkg::ST_IDLE: begin
				if (evt_valid) begin
					mode_q <= evt.mode;
					num_q  <= evt.exc_number;
				end
			end
			exc_nest_pkg::ST_CHECK: begin
				if (chk_done) begin
					rec0_q <= plan0;
					rec1_q <= plan1;
					ovf_q  <= chk_ovf;
				end
			end
			exc_nest_pkg::ST_SEEN_WR: begin
				out_q.rec_number     <= rec0_q.number;
				out_q.rec_action     <= rec0_q.action;
				out_q.rec_origin     <= rec0_q.origin;
				out_q.first_seen     <= first;
				out_q.stack_overflow <= ovf_q;
				out_q.last           <= (nrem_q == 2'd1);
			end
			exc_nest_pkg::ST_OUT: begin
				// advance to the second record
				if (!rec_stall) begin
					rec0_q <= rec1_q;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_ovf_source: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec.stack_overflow |->
			mode_q == exc_nest_pkg::MODE_ENTERED && full)
		else $error("overflow flag without a full stack on enter");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_stall && rec.last |=> state_q == exc_nest_pkg::ST_IDLE)
		else $error("sequencer not idle after final record");

	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec.last |-> nrem_q == 2'd2)
		else $error("non-final record without a second pending");

	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!active_valid_q |-> active_num_q == '0)
		else $error("inactive context holds a number");

endmodule
`default_nettype wire

// ===== test/exception_nesting_tracker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Exception nesting tracker checker
// Watches the event and record channels, predicts the lane records of every
// accepted event and compares each record transfer with the oldest one due.
// ----------------------------------------------------------------------------
module exception_nesting_tracker_checker
	import exc_nest_pkg::*;
#(
	parameter int STACK_DEPTH    = 32,
	parameter int NUM_EXCEPTIONS = 512
) (
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	input  logic evt_stall,
	input  evt_t evt,
	input  logic rec_valid,
	input  logic rec_stall,
	input  rec_t rec,
	output int   mismatches,
	output int   records_pending,
	output int   records_checked,
	output int   overflow_records
);

	localparam int REPORT_LIMIT = 10;

	stk_entry_t       nest[STACK_DEPTH];
	int               nest_depth = 0;
	logic             ctx_valid = 1'b0;
	logic [NUM_W-1:0] ctx_number = '0;
	logic             seen_map[NUM_EXCEPTIONS] = '{default: 1'b0};
	rec_t             event_recs[$];
	rec_t             due_recs[$];

	int fail_count = 0;
	int pending_cnt = 0;
	int checked_cnt = 0;
	int ovf_cnt = 0;

	assign mismatches       = fail_count;
	assign records_pending  = pending_cnt;
	assign records_checked  = checked_cnt;
	assign overflow_records = ovf_cnt;

	function automatic string rec_str(input rec_t r);
		return $sformatf("num %0d action %0d origin %0d first %0d ovf %0d last %0d",
			r.rec_number, r.rec_action, r.rec_origin, r.first_seen,
			r.stack_overflow, r.last);
	endfunction

	// queue one record of the current event; the first sighting marks the map
	task automatic add_record(input logic [NUM_W-1:0] num, input logic [1:0] action,
			input logic origin);
		rec_t r;
		r = '0;
		r.rec_number = num;
		r.rec_action = action;
		r.rec_origin = origin;
		if (num < NUM_EXCEPTIONS && !seen_map[num]) begin
			seen_map[num] = 1'b1;
			r.first_seen = 1'b1;
		end
		event_recs = {event_recs, r};
	endtask

	task automatic switch_context(input logic [NUM_W-1:0] num, input logic [1:0] action,
			input logic origin);
		if (ctx_valid && ctx_number == num) begin
			if (action == ACT_RETURN)
				add_record(num, action, origin);
		end else begin
			if (ctx_valid)
				add_record(ctx_number, ACT_EXIT, ORG_SYNTH);
			add_record(num, action, origin);
			ctx_valid = 1'b1;
			ctx_number = num;
		end
	endtask

	task automatic close_context(input logic origin);
		if (ctx_valid) begin
			add_record(ctx_number, ACT_EXIT, origin);
			ctx_valid = 1'b0;
			ctx_number = '0;
		end
	endtask

	function automatic logic [NUM_W-1:0] nest_top();
		return (nest_depth > 0) ? nest[nest_depth-1].number : '0;
	endfunction

	task automatic predict_event(input evt_t e);
		logic dropped;
		dropped = 1'b0;
		event_recs.delete();
		case (e.mode)
		MODE_ENTERED: begin
			if (nest_depth >= STACK_DEPTH) begin
				dropped = 1'b1;
			end else begin
				if (nest_depth > 0)
					nest[nest_depth-1].running = 1'b0;
				nest[nest_depth].number = e.exc_number;
				nest[nest_depth].running = 1'b1;
				nest_depth++;
			end
			switch_context(nest_top(), ACT_ENTER, ORG_TRACE);
		end
		MODE_EXITED: begin
			if (nest_depth > 0 && nest[nest_depth-1].number == e.exc_number &&
					nest[nest_depth-1].running) begin
				nest_depth--;
				close_context(ORG_TRACE);
			end
		end
		MODE_RETURNED: begin
			while (nest_depth > 0 && nest[nest_depth-1].number != e.exc_number)
				nest_depth--;
			if (nest_depth > 0) begin
				nest[nest_depth-1].running = 1'b1;
			end else if (e.exc_number != 0) begin
				nest[0].number = e.exc_number;
				nest[0].running = 1'b1;
				nest_depth = 1;
			end
			switch_context(nest_top(), ACT_RETURN, ORG_TRACE);
		end
		MODE_START: switch_context('0, ACT_ENTER, ORG_SYNTH);
		MODE_DISCONT: begin
			nest_depth = 0;
			close_context(ORG_SYNTH);
		end
		default: ;
		endcase
		foreach (event_recs[i]) begin
			event_recs[i].stack_overflow = dropped;
			event_recs[i].last = (i == event_recs.size() - 1);
			due_recs = {due_recs, event_recs[i]};
		end
	endtask

	task automatic check_record(input rec_t got);
		rec_t want;
		if (due_recs.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: record with nothing due: %s", $realtime, rec_str(got));
		end else begin
			want = due_recs.pop_front();
			checked_cnt++;
			if (want.stack_overflow)
				ovf_cnt++;
			if (got.rec_number !== want.rec_number || got.rec_action !== want.rec_action ||
					got.rec_origin !== want.rec_origin ||
					got.first_seen !== want.first_seen ||
					got.stack_overflow !== want.stack_overflow ||
					got.last !== want.last) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("%0t: record mismatch: expected %s, got %s", $realtime,
						rec_str(want), rec_str(got));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nest_depth = 0;
			ctx_valid = 1'b0;
			ctx_number = '0;
			foreach (seen_map[i])
				seen_map[i] = 1'b0;
			due_recs.delete();
			pending_cnt <= 0;
		end else begin
			// records of an older event go first when both channels move together
			if (rec_valid && !rec_stall)
				check_record(rec);
			if (evt_valid && !evt_stall)
				predict_event(evt);
			pending_cnt <= due_recs.size();
		end
	end

endmodule

// ===== test/exception_nesting_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Exception nesting tracker testbench
// Drives directed and randomized trace event streams into the tracker with
// bursty input and a stalling record sink; a side checker predicts and
// compares every lane record, and this top gives the verdict.
// ----------------------------------------------------------------------------
module exception_nesting_tracker_tb;
	import exc_nest_pkg::*;

	localparam int STACK_DEPTH    = 32;
	localparam int NUM_EXCEPTIONS = 512;
	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_EVENTS  = 800;
	localparam int LONG_HOLD      = 300;
	localparam int IDLE_LIMIT     = 4000;
	localparam int SETTLE_CYCLES  = 60;
	localparam int POOL_SIZE      = 10;

	// modes the block has no use for
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	typedef enum int {RX_FREE, RX_RANDOM, RX_TOGGLE} rx_regime_e;
	typedef enum int {EP_NESTED, EP_DEEP, EP_NOISE} episode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic rec_valid;
	logic rec_stall = 1'b0;
	rec_t rec;

	int rec_mismatches;
	int recs_pending;
	int recs_checked;
	int ovf_recs;

	int idle_cycles = 0;
	int burst_left = 0;
	int live_events = 0;
	int mode_count[8] = '{default: 0};
	bit long_hold_req = 1'b0;

	// numbers reused often so that nesting and returns find their match
	logic [NUM_W-1:0] num_pool[POOL_SIZE];
	// rough view of the nesting, used only to shape well-formed sequences
	logic [NUM_W-1:0] nest_hint[$];

	always #(CLK_PERIOD / 2) clk = ~clk;

	exception_nesting_tracker #(
		.STACK_DEPTH(STACK_DEPTH),
		.NUM_EXCEPTIONS(NUM_EXCEPTIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec)
	);

	exception_nesting_tracker_checker #(
		.STACK_DEPTH(STACK_DEPTH),
		.NUM_EXCEPTIONS(NUM_EXCEPTIONS)
	) rec_chk (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec(rec),
		.mismatches(rec_mismatches),
		.records_pending(recs_pending),
		.records_checked(recs_checked),
		.overflow_records(ovf_recs)
	);

	// Watchdog: count cycles without a transfer on either channel. The longest
	// legal quiet stretch is the seen-map sweep after reset or the long sink
	// hold-off, both far below the limit.
	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (rec_valid && !rec_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d records still due",
				idle_cycles, recs_pending);
			$display("exception_nesting_tracker_tb: FAIL");
			$finish;
		end
	end

	// Record sink: switch between free-running, random and toggling stall
	// regimes; on request hold off for a long stretch so that the tracker backs
	// up and stalls its event input.
	initial begin : record_sink
		rx_regime_e regime;
		int regime_left;
		int stall_pct;
		int hold_left;
		regime = RX_FREE;
		regime_left = 0;
		stall_pct = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rec_stall <= 1'b1;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				rec_stall <= 1'b1;
			end else begin
				if (regime_left == 0) begin
					regime = rx_regime_e'($urandom_range(0, 2));
					regime_left = $urandom_range(4, 60);
					stall_pct = $urandom_range(10, 90);
				end
				regime_left--;
				case (regime)
				RX_FREE:   rec_stall <= 1'b0;
				RX_RANDOM: rec_stall <= ($urandom_range(0, 99) < stall_pct);
				default:   rec_stall <= ~rec_stall;
				endcase
			end
		end
	end

	function automatic logic [NUM_W-1:0] pick_number();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return num_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 70 && nest_hint.size() > 0)
			return nest_hint[$urandom_range(0, nest_hint.size() - 1)];
		if (r < 75)
			return '0;
		if (r < 80)
			return '1;
		return NUM_W'($urandom_range(0, 511));
	endfunction

	// Offer one event and hold it until the transfer. Between bursts, drop
	// valid for a random gap; some bursts run long with no gap at all.
	task automatic offer(input logic [2:0] evt_mode, input logic [NUM_W-1:0] evt_num);
		evt_t item;
		int gap;
		item.mode = evt_mode;
		item.exc_number = evt_num;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				evt_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		evt_valid <= 1'b1;
		evt <= item;
		do @(posedge clk); while (evt_stall);
		mode_count[evt_mode]++;
		if (evt_mode <= MODE_DISCONT && evt_mode != MODE_UNKNOWN)
			live_events++;
		// track nesting loosely for the next well-formed choices
		case (evt_mode)
		MODE_ENTERED: begin
			if (nest_hint.size() < STACK_DEPTH)
				nest_hint = {nest_hint, evt_num};
		end
		MODE_EXITED: begin
			if (nest_hint.size() > 0 && nest_hint[$] == evt_num)
				nest_hint.delete(nest_hint.size() - 1);
		end
		MODE_RETURNED: begin
			while (nest_hint.size() > 0 && nest_hint[$] != evt_num)
				nest_hint.delete(nest_hint.size() - 1);
			if (nest_hint.size() == 0 && evt_num != 0)
				nest_hint = {nest_hint, evt_num};
		end
		MODE_DISCONT: nest_hint.delete();
		default: ;
		endcase
	endtask

	// Pause the sender until every predicted record has transferred.
	task automatic drain();
		evt_valid <= 1'b0;
		do @(posedge clk); while (recs_pending != 0);
		burst_left = 0;
	endtask

	initial begin : stimulus
		int ep;
		int r;
		int len;
		int idx;
		int base;
		episode_e kind;
		logic [NUM_W-1:0] next_top;

		foreach (num_pool[i])
			num_pool[i] = NUM_W'($urandom_range(1, 510));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// thread start from nothing, then a context switch to the top number
		offer(MODE_START, 9'd0);
		offer(MODE_ENTERED, 9'd511);
		// thread mode pushed as an exception, then closed by its exit
		offer(MODE_ENTERED, 9'd0);
		offer(MODE_EXITED, 9'd0);
		// exit of a preempted entry is ignored
		offer(MODE_EXITED, 9'd511);
		// return resumes it; a second return to the same context still reports
		offer(MODE_RETURNED, 9'd511);
		offer(MODE_RETURNED, 9'd511);
		// unknown and unused modes leave no trace
		offer(MODE_UNKNOWN, 9'd5);
		offer(MODE_SPARE_6, 9'd100);
		offer(MODE_SPARE_7, 9'd511);
		// return to a number not on the stack empties it and pushes the number
		offer(MODE_RETURNED, 9'd300);
		// return to thread mode empties the stack without a push
		offer(MODE_RETURNED, 9'd0);
		// two-level nesting unwound by a return, then a plain exit
		offer(MODE_ENTERED, 9'd1);
		offer(MODE_ENTERED, 9'd2);
		offer(MODE_RETURNED, 9'd1);
		offer(MODE_EXITED, 9'd1);
		// discontinuity with and without an active context
		offer(MODE_DISCONT, 9'd0);
		offer(MODE_START, 9'd256);
		offer(MODE_DISCONT, 9'd170);
		offer(MODE_DISCONT, 9'd85);
		// exit on an empty stack
		offer(MODE_EXITED, 9'd7);
		drain();

		// --- random part ---
		base = live_events;
		ep = 0;
		while (live_events - base < RANDOM_EVENTS) begin
			if (ep == 4 || ep == 30)
				long_hold_req = 1'b1;
			if (ep > 0 && $urandom_range(0, 9) == 0)
				drain();
			r = $urandom_range(0, 19);
			if (ep == 0)
				kind = EP_DEEP;
			else
				kind = (r < 14) ? EP_NESTED : (r < 16) ? EP_DEEP : EP_NOISE;

			case (kind)
			EP_NESTED: begin
				// realistic interrupt nesting: enter, exit, return to the preempted one
				len = $urandom_range(6, 30);
				repeat (len) begin
					r = $urandom_range(0, 99);
					if (nest_hint.size() == 0 || (r < 40 && nest_hint.size() < 8)) begin
						offer(MODE_ENTERED, pick_number());
					end else if (r < 80) begin
						offer(MODE_EXITED, nest_hint[$]);
						next_top = '0;
						if (nest_hint.size() > 0)
							next_top = nest_hint[$];
						offer(MODE_RETURNED, next_top);
					end else if (r < 90) begin
						idx = $urandom_range(0, nest_hint.size() - 1);
						offer(MODE_RETURNED, nest_hint[idx]);
					end else if (r < 96) begin
						offer(MODE_START, pick_number());
					end else begin
						offer(MODE_UNKNOWN, pick_number());
					end
				end
			end
			EP_DEEP: begin
				// fill the stack past its depth; a thread start in between makes
				// the dropped pushes show up on the records
				len = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
				repeat (len) offer(MODE_ENTERED, pick_number());
				repeat ($urandom_range(1, 3)) begin
					offer(MODE_START, pick_number());
					offer(MODE_ENTERED, pick_number());
				end
				if ($urandom_range(0, 1) == 0)
					offer(MODE_RETURNED, '0);
				else
					offer(MODE_DISCONT, pick_number());
			end
			default: begin
				// raw noise over every mode and number
				len = $urandom_range(4, 16);
				repeat (len)
					offer(3'($urandom_range(0, 7)), NUM_W'($urandom_range(0, 511)));
			end
			endcase
			ep++;
		end

		// wait out every record due, then let a stray one surface
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d events: %0d entered, %0d exited, %0d returned, %0d thread starts,",
			mode_count.sum(), mode_count[MODE_ENTERED], mode_count[MODE_EXITED],
			mode_count[MODE_RETURNED], mode_count[MODE_START]);
		$display("  %0d discontinuities, %0d ignored; %0d records checked, %0d with overflow.",
			mode_count[MODE_DISCONT],
			mode_count[MODE_UNKNOWN] + mode_count[MODE_SPARE_6] + mode_count[MODE_SPARE_7],
			recs_checked, ovf_recs);
		if (rec_mismatches == 0 && recs_pending == 0)
			$display("exception_nesting_tracker_tb: PASS");
		else
			$display("exception_nesting_tracker_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/exc_nest_pkg.sv
rtl/core/exc_nest_ram.sv
rtl/core/exception_nesting_tracker.sv
test/exception_nesting_tracker_checker.sv
test/exception_nesting_tracker_tb.sv
